// File: rtl/bblur_pkg.sv
// Shared types, constants and the reciprocal table of the 3x3 box blur.
`default_nettype none

package bblur_pkg;

    // Channel and pixel widths.
    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;

    // Configuration port.
    localparam int APB_DW      = 32;
    localparam int PADDR_W     = 3;
    localparam int IMG_W_BITS  = 13;
    localparam int IMG_H_BITS  = 16;
    localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 16'd480;

    // Register indexes, taken from address bit 2.
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Neighborhood sum and reciprocal multiply.
    localparam int SUM_W       = 12;
    localparam int ROW_SUM_W   = 10;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 21;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Position of an item inside the frame, as the result logic needs it.
    typedef struct packed {
        logic c_ge1;
        logic c_ge2;
        logic last_col;
        logic r_ge1;
        logic r_ge2;
        logic last_row;
    } pos_flags_t;

    // Reciprocal of the neighbor count, rounded up, scaled by 2**RECIP_SHIFT.
    // Exact for every sum below 2**RECIP_SHIFT / 8.
    function automatic logic [RECIP_W-1:0] bblur_recip(
        input logic [1:0] nrows,
        input logic [1:0] ncols
    );
        logic [3:0] cnt;
        cnt = {2'b00, nrows} * {2'b00, ncols};
        case (cnt)
            4'd1:    return 21'd1048576;
            4'd2:    return 21'd524288;
            4'd3:    return 21'd349526;
            4'd4:    return 21'd262144;
            4'd6:    return 21'd174763;
            4'd9:    return 21'd116509;
            default: return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

// File: rtl/bblur_if.sv
// Pixel input and result output channel interfaces of the box blur.
`default_nettype none

interface bblur_in_if;
    import bblur_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] chan0_in;
    logic [CH_W-1:0] chan1_in;
    logic [CH_W-1:0] chan2_in;

    modport source (output valid, chan0_in, chan1_in, chan2_in, input ready);
    modport sink   (input valid, chan0_in, chan1_in, chan2_in, output ready);
endinterface

interface bblur_out_if;
    import bblur_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] chan0_out;
    logic [CH_W-1:0] chan1_out;
    logic [CH_W-1:0] chan2_out;
    logic            frame_end;
    logic            run_end;

    modport source (output valid, chan0_out, chan1_out, chan2_out, frame_end, run_end,
                    input ready);
    modport sink   (input valid, chan0_out, chan1_out, chan2_out, frame_end, run_end,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/bblur_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bblur_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

// File: rtl/box_blur_3x3_stream.sv
// Path: an accepted item moves through stage 1 and the window into the output register.
// Throughput: one item per cycle while each item releases at most one result and the
// output is not stalled; an item that releases n results (row ends, last row) holds
// the input back, since the single result register takes one result per cycle.
// Reset: counters clear, the frame is 640 x 480; the two row RAMs are not cleared,
// as entries outside the image never count toward a mean.
`default_nettype none

module box_blur_3x3_stream #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bblur_pkg::PADDR_W-1:0]    paddr,
    input  logic [bblur_pkg::APB_DW-1:0]     pwdata,
    output logic [bblur_pkg::APB_DW-1:0]     prdata,
    output logic                             pready,
    bblur_in_if.sink                         pix_in,
    bblur_out_if.source                      pix_out
);
    import bblur_pkg::*;

    localparam int          CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [15:0] MAX_W16 = 16'(MAX_WIDTH);

    // Configuration registers.
    logic [IMG_W_BITS-1:0] image_width_reg;
    logic [IMG_H_BITS-1:0] image_height_reg;
    logic                  cfg_wr;

    // Frame position counters.
    logic [CW-1:0]         col_cnt_reg;
    logic [15:0]           row_cnt_reg;
    logic [15:0]           eff_w;
    logic [15:0]           eff_h;
    logic [15:0]           col_ext;
    pos_flags_t            pos_now;

    // Stage 1: accepted item waiting for its window shift.
    logic                  s1_valid_reg;
    logic [PIX_W-1:0]      s1_pix_reg;
    logic [CW-1:0]         s1_col_reg;
    pos_flags_t            s1_pos_reg;

    // Row RAM read data and the bypass for a read of the address just written.
    logic [PIX_W-1:0]      rd_older;
    logic [PIX_W-1:0]      rd_newer;
    logic                  byp_valid_reg;
    logic [PIX_W-1:0]      byp_older_reg;
    logic [PIX_W-1:0]      byp_newer_reg;
    logic [PIX_W-1:0]      top_cur;
    logic [PIX_W-1:0]      mid_cur;

    // Stage 2: window and result sequencing.
    logic [PIX_W-1:0]      win_reg [3][3];
    logic                  s2_valid_reg;
    pos_flags_t            s2_pos_reg;
    logic                  ri_reg;
    logic                  ci_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [CH_W-1:0]       out_chan0_reg;
    logic [CH_W-1:0]       out_chan1_reg;
    logic [CH_W-1:0]       out_chan2_reg;
    logic                  out_frame_end_reg;
    logic                  out_run_end_reg;

    // Handshake and flow control.
    logic                  accept;
    logic                  emit_ok;
    logic                  two_rows;
    logic                  two_cols;
    logic                  has_results;
    logic                  last_result;
    logic                  s2_emit;
    logic                  s2_done;
    logic                  s1_move;

    // Result datapath.
    logic [1:0]            sel_wr;
    logic [1:0]            sel_wc;
    logic [2:0]            row_in;
    logic [2:0]            col_in;
    logic [ROW_SUM_W-1:0]  row_sum [3];
    logic [SUM_W-1:0]      total;
    logic [1:0]            nrows;
    logic [1:0]            ncols;
    logic [PROD_W-1:0]     prod;
    logic [PIX_W-1:0]      centre;

    // APB write strobe and read mux.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = APB_DW'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[IMG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[IMG_H_BITS-1:0];
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    // Effective frame size: zero acts as one, width is limited to the row RAM depth.
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            eff_w = 16'd1;
        end
        else if (16'(image_width_reg) > MAX_W16)
        begin
            eff_w = MAX_W16;
        end
        else
        begin
            eff_w = 16'(image_width_reg);
        end
        eff_h = (image_height_reg == '0) ? 16'd1 : image_height_reg;
    end

    // Position flags of the item at the input.
    assign col_ext          = 16'(col_cnt_reg);
    assign pos_now.c_ge1    = (col_ext != 16'd0);
    assign pos_now.c_ge2    = (col_ext > 16'd1);
    assign pos_now.last_col = (col_ext == eff_w - 16'd1);
    assign pos_now.r_ge1    = (row_cnt_reg != 16'd0);
    assign pos_now.r_ge2    = (row_cnt_reg > 16'd1);
    assign pos_now.last_row = (row_cnt_reg == eff_h - 16'd1);

    assign accept       = pix_in.valid && pix_in.ready;
    assign pix_in.ready = !s1_valid_reg || s1_move;

    // Column and row counters; a register write starts a new frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (pos_now.last_col)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= pos_now.last_row ? 16'd0 : row_cnt_reg + 16'd1;
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + CW'(1);
            end
        end
    end

    // Stage 1 register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= {pix_in.chan2_in, pix_in.chan1_in, pix_in.chan0_in};
            s1_col_reg <= col_cnt_reg;
            s1_pos_reg <= pos_now;
        end
    end

    // Row RAMs: read at acceptance, written when the item shifts into the window.
    bblur_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_older (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_col_reg),
        .wdata (mid_cur),
        .re    (accept),
        .raddr (col_cnt_reg),
        .rdata (rd_older)
    );

    bblur_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_newer (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (accept),
        .raddr (col_cnt_reg),
        .rdata (rd_newer)
    );

    // Bypass when the accepted item reads the column written in the same cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            byp_valid_reg <= s1_move && (s1_col_reg == col_cnt_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byp_older_reg <= mid_cur;
            byp_newer_reg <= s1_pix_reg;
        end
    end

    assign top_cur = byp_valid_reg ? byp_older_reg : rd_older;
    assign mid_cur = byp_valid_reg ? byp_newer_reg : rd_newer;

    // Result sequencing of the item in the window, in row-major order.
    assign emit_ok     = !out_valid_reg || pix_out.ready;
    assign two_rows    = s2_pos_reg.r_ge1 && s2_pos_reg.last_row;
    assign two_cols    = s2_pos_reg.c_ge1 && s2_pos_reg.last_col;
    assign has_results = (s2_pos_reg.r_ge1 || s2_pos_reg.last_row)
                         && (s2_pos_reg.c_ge1 || s2_pos_reg.last_col);
    assign last_result = (ri_reg == two_rows) && (ci_reg == two_cols);
    assign s2_emit     = s2_valid_reg && has_results && emit_ok;
    assign s2_done     = s2_valid_reg && (!has_results || (emit_ok && last_result));
    assign s1_move     = s1_valid_reg && (!s2_valid_reg || s2_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            ri_reg       <= 1'b0;
            ci_reg       <= 1'b0;
        end
        else if (s1_move)
        begin
            s2_valid_reg <= 1'b1;
            ri_reg       <= 1'b0;
            ci_reg       <= 1'b0;
        end
        else if (s2_done)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_emit)
        begin
            if (ci_reg != two_cols)
            begin
                ci_reg <= 1'b1;
            end
            else
            begin
                ci_reg <= 1'b0;
                ri_reg <= 1'b1;
            end
        end
    end

    // Window shift: the newest column is the two row RAM words and the item.
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_pos_reg <= s1_pos_reg;
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= top_cur;
            win_reg[1][2] <= mid_cur;
            win_reg[2][2] <= s1_pix_reg;
        end
    end

    // Centre of the current result and its in-image neighbors.
    assign sel_wr = (s2_pos_reg.r_ge1 && !ri_reg) ? 2'd1 : 2'd2;
    assign sel_wc = (s2_pos_reg.c_ge1 && !ci_reg) ? 2'd1 : 2'd2;
    assign row_in = {1'b1, s2_pos_reg.r_ge1, s2_pos_reg.r_ge2}
                    & ((sel_wr == 2'd2) ? 3'b110 : 3'b111);
    assign col_in = {1'b1, s2_pos_reg.c_ge1, s2_pos_reg.c_ge2}
                    & ((sel_wc == 2'd2) ? 3'b110 : 3'b111);
    assign nrows  = 2'($countones(row_in));
    assign ncols  = 2'($countones(col_in));
    assign centre = win_reg[sel_wr][sel_wc];

    // Neighborhood sum: three row sums, then their total.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            row_sum[k] = (col_in[0] ? ROW_SUM_W'(win_reg[k][0][CH_W-1:0]) : '0)
                       + (col_in[1] ? ROW_SUM_W'(win_reg[k][1][CH_W-1:0]) : '0)
                       + (col_in[2] ? ROW_SUM_W'(win_reg[k][2][CH_W-1:0]) : '0);
        end
        total = (row_in[0] ? SUM_W'(row_sum[0]) : '0)
              + (row_in[1] ? SUM_W'(row_sum[1]) : '0)
              + (row_in[2] ? SUM_W'(row_sum[2]) : '0);
    end

    // Truncated mean by multiplying with the reciprocal of the count.
    assign prod = PROD_W'(total) * PROD_W'(bblur_recip(nrows, ncols));

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_emit)
        begin
            out_chan0_reg     <= prod[RECIP_SHIFT +: CH_W];
            out_chan1_reg     <= centre[CH_W +: CH_W];
            out_chan2_reg     <= centre[2*CH_W +: CH_W];
            out_frame_end_reg <= (sel_wr == 2'd2) && (sel_wc == 2'd2);
            out_run_end_reg   <= last_result;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.chan0_out = out_chan0_reg;
    assign pix_out.chan1_out = out_chan1_reg;
    assign pix_out.chan2_out = out_chan2_reg;
    assign pix_out.frame_end = out_frame_end_reg;
    assign pix_out.run_end   = out_run_end_reg;
endmodule

`default_nettype wire

// File: rtl/bblur_chk.sv
// Port-level checker for the box blur, bound to the top level.
`default_nettype none

module bblur_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bblur_pkg::CH_W-1:0]    out_chan0,
    input logic [bblur_pkg::CH_W-1:0]    out_chan1,
    input logic [bblur_pkg::CH_W-1:0]    out_chan2,
    input logic                          out_frame_end,
    input logic                          out_run_end,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic                          pready,
    input logic [bblur_pkg::PADDR_W-1:0] paddr,
    input logic [bblur_pkg::APB_DW-1:0]  pwdata,
    input logic [bblur_pkg::APB_DW-1:0]  prdata
);
    import bblur_pkg::*;

    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable({out_chan0, out_chan1, out_chan2, out_frame_end, out_run_end}))
        else $error("result payload changed while stalled");

    // The last pixel of a frame is always the last result of its item.
    a_frame_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_frame_end |-> out_run_end)
        else $error("frame end without run end");

    // A width write reads back in the next cycle.
    a_width_rb: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && (paddr[2] == REG_IMAGE_WIDTH)) ##1 (paddr[2] == REG_IMAGE_WIDTH) |->
            prdata == APB_DW'($past(pwdata[IMG_W_BITS-1:0]))
        )
        else $error("image width read back differs from written value");
endmodule

bind box_blur_3x3_stream bblur_chk u_bblur_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (pix_out.valid),
    .out_ready     (pix_out.ready),
    .out_chan0     (pix_out.chan0_out),
    .out_chan1     (pix_out.chan1_out),
    .out_chan2     (pix_out.chan2_out),
    .out_frame_end (pix_out.frame_end),
    .out_run_end   (pix_out.run_end),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);

`default_nettype wire
